### design/hsfd_pkg.sv
// Shared types, constants and the CRC-8 step for the humidity sensor frame decoder.
package hsfd_pkg;

    // Position of the next byte within a six-byte measurement frame.
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } hsfd_pos_t;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [16:0] WORD_MAX    = 17'd65535;

    // Status bit positions.
    localparam int STATUS_TEMP_BAD = 0;
    localparam int STATUS_HUM_BAD  = 1;

    // One complete frame as handed from the front end to the scaling stage.
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic [1:0]  status;
    } hsfd_rec_t;

    // Queue occupancy flags.
    typedef struct packed {
        logic full;
        logic empty;
    } hsfd_q_status_t;

    // One byte of CRC-8, polynomial 0x31, MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

### design/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder: front end, frame queue and scaling stage.
//
//  Channel  | Direction | Signals                     | Contents
//  ---------+-----------+-----------------------------+-----------------------------------------
//  s_axis   | in        | tvalid, tready, tdata, tuser| tdata[7:0] rx_byte; tuser[0] frame_start
//  m_axis   | out       | tvalid, tready, tdata, tuser| tdata[14:0] temperature_centi,
//           |           |                             | tdata[28:15] humidity_centi; tuser status
//
// One byte is taken in every cycle; the front end stalls only when the frame queue is full.
// A result follows the transaction carrying the sixth byte of a frame: the frame enters
// the queue at that same edge, the stage-one registers then take the constant products,
// and after them the output register takes the result of the divide by 65535.
// The back end stalls as a whole while a result waits, and the queue lets the front end
// keep taking bytes meanwhile.
// Reset (rst_n low, asynchronous) returns the frame position to the first byte and empties
// the queue and the pipeline.
module humidity_sensor_frame_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi, zero fill
    output logic [1:0]  m_axis_tuser    // [1:0] status: bit 0 temperature CRC bad, bit 1 humidity
);

    logic                     byte_accept;
    logic                     push;
    logic                     pop;
    hsfd_pkg::hsfd_rec_t      push_rec;
    hsfd_pkg::hsfd_rec_t      pop_rec;
    hsfd_pkg::hsfd_q_status_t q_stat;
    logic signed [14:0]       temperature_centi;
    logic [13:0]              humidity_centi;

    // The front end only pushes on the last byte of a frame, but holding off whenever the
    // queue is full keeps that decision free of the byte position.
    assign s_axis_tready = !q_stat.full;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .push_rec    (push_rec)
    );

    hsfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .q_stat   (q_stat)
    );

    hsfd_scale u_scale (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_rec           (pop_rec),
        .q_stat            (q_stat),
        .pop               (pop),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .status            (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, humidity_centi, temperature_centi};

`ifndef ASSERT_OFF
    // A frame is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("frame pushed into a full queue");

    // The scaling stage never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    // Scaled humidity never exceeds full scale.
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (humidity_centi <= 14'd10000))
        else $error("humidity out of range");

    // Scaled temperature stays within the sensor span.
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000))
        else $error("temperature out of range");
`endif

endmodule

### design/hsfd_front.sv
// Front end: tracks the byte position, runs the CRC and assembles complete frames.
module hsfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                push,
    output hsfd_pkg::hsfd_rec_t push_rec
);

    hsfd_pkg::hsfd_pos_t pos_reg, pos_next, eff_pos;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [7:0]  hum_hi_reg, hum_hi_next;
    logic [15:0] hum_word_reg, hum_word_next;
    logic        temp_bad_reg, temp_bad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= hsfd_pkg::POS_T_HI;
            crc_reg       <= hsfd_pkg::CRC_INIT;
            temp_word_reg <= '0;
            hum_hi_reg    <= '0;
            hum_word_reg  <= '0;
            temp_bad_reg  <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_hi_reg    <= hum_hi_next;
            hum_word_reg  <= hum_word_next;
            temp_bad_reg  <= temp_bad_next;
        end
    end

    always_comb
    begin
        // A start mark restarts the frame on this byte.
        if (frame_start || pos_reg > hsfd_pkg::POS_H_CRC)
            eff_pos = hsfd_pkg::POS_T_HI;
        else
            eff_pos = pos_reg;

        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_hi_next    = hum_hi_reg;
        hum_word_next  = hum_word_reg;
        temp_bad_next  = temp_bad_reg;
        push           = 1'b0;
        push_rec.temp_word = temp_word_reg;
        push_rec.hum_word  = hum_word_reg;
        push_rec.status    = {crc_reg != rx_byte, temp_bad_reg};

        if (byte_accept)
        begin
            case (eff_pos)
                hsfd_pkg::POS_T_HI:
                begin
                    crc_next       = hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, rx_byte);
                    temp_word_next = {rx_byte, 8'h00};
                    pos_next       = hsfd_pkg::POS_T_LO;
                end
                hsfd_pkg::POS_T_LO:
                begin
                    crc_next       = hsfd_pkg::crc8_update(crc_reg, rx_byte);
                    temp_word_next = {temp_word_reg[15:8], rx_byte};
                    pos_next       = hsfd_pkg::POS_T_CRC;
                end
                hsfd_pkg::POS_T_CRC:
                begin
                    temp_bad_next = (crc_reg != rx_byte);
                    crc_next      = hsfd_pkg::CRC_INIT;
                    pos_next      = hsfd_pkg::POS_H_HI;
                end
                hsfd_pkg::POS_H_HI:
                begin
                    crc_next    = hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, rx_byte);
                    hum_hi_next = rx_byte;
                    pos_next    = hsfd_pkg::POS_H_LO;
                end
                hsfd_pkg::POS_H_LO:
                begin
                    crc_next      = hsfd_pkg::crc8_update(crc_reg, rx_byte);
                    hum_word_next = {hum_hi_reg, rx_byte};
                    pos_next      = hsfd_pkg::POS_H_CRC;
                end
                hsfd_pkg::POS_H_CRC:
                begin
                    push     = 1'b1;
                    crc_next = hsfd_pkg::CRC_INIT;
                    pos_next = hsfd_pkg::POS_T_HI;
                end
                default:
                begin
                    pos_next = hsfd_pkg::POS_T_HI;
                end
            endcase
        end
    end

endmodule

### design/hsfd_fifo.sv
// Short frame queue between the front end and the scaling stage.
module hsfd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hsfd_pkg::hsfd_rec_t      push_rec,
    input  logic                     pop,
    output hsfd_pkg::hsfd_rec_t      pop_rec,
    output hsfd_pkg::hsfd_q_status_t q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0]   DEPTH_C = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

    hsfd_pkg::hsfd_rec_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + (AW + 1)'(push) - (AW + 1)'(pop);
    end

    assign pop_rec      = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == DEPTH_C);
    assign q_stat.empty = (count_reg == '0);

endmodule

### design/hsfd_scale.sv
// Back end: scales the raw words to hundredths and holds the result for the output channel.
module hsfd_scale (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hsfd_pkg::hsfd_rec_t      pop_rec,
    input  hsfd_pkg::hsfd_q_status_t q_stat,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [14:0]       temperature_centi,
    output logic [13:0]              humidity_centi,
    output logic [1:0]               status
);

    logic        advance;
    logic        s1_valid_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;
    logic [1:0]  s1_status_reg;

    logic        out_valid_reg;
    logic [14:0] out_temp_reg, out_temp_next;
    logic [13:0] out_hum_reg, out_hum_next;
    logic [1:0]  out_status_reg;

    logic [14:0] t_q0;
    logic [16:0] t_r0;
    logic [14:0] t_q;
    logic [13:0] h_q0;
    logic [16:0] h_r0;

    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_stat.empty;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tprod_reg   <= 31'(pop_rec.temp_word) * 31'(hsfd_pkg::TEMP_SPAN);
            s1_hprod_reg   <= 30'(pop_rec.hum_word) * 30'(hsfd_pkg::HUM_SPAN);
            s1_status_reg  <= pop_rec.status;
            out_temp_reg   <= out_temp_next;
            out_hum_reg    <= out_hum_next;
            out_status_reg <= s1_status_reg;
        end
    end

    // Division by 65535: x = q0*65536 + lo, so x - q0*65535 = lo + q0, which stays
    // below twice the divisor, hence a single correction step.
    always_comb
    begin
        t_q0 = s1_tprod_reg[30:16];
        t_r0 = {1'b0, s1_tprod_reg[15:0]} + 17'(t_q0);
        t_q  = t_q0 + 15'(t_r0 >= hsfd_pkg::WORD_MAX);
        out_temp_next = t_q - hsfd_pkg::TEMP_OFFSET;

        h_q0 = s1_hprod_reg[29:16];
        h_r0 = {1'b0, s1_hprod_reg[15:0]} + 17'(h_q0);
        out_hum_next = h_q0 + 14'(h_r0 >= hsfd_pkg::WORD_MAX);
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = out_temp_reg;
    assign humidity_centi    = out_hum_reg;
    assign status            = out_status_reg;

endmodule

### tb/humidity_sensor_frame_decoder_checker.sv
// Checker for the humidity sensor frame decoder: predicts each reading and compares it.
`timescale 1ns / 100ps

module humidity_sensor_frame_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi, zero fill
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          mismatches,
    output int          awaited
);

    localparam int unsigned DEG_SPAN_CENTI   = 17500;
    localparam int          DEG_OFFSET_CENTI = 4500;
    localparam int unsigned RH_SPAN_CENTI    = 10000;
    localparam int unsigned FULL_SCALE       = 65535;

    typedef struct packed {
        logic [14:0] temp_centi;
        logic [13:0] hum_centi;
        logic [1:0]  status;
    } reading_t;

    reading_t            awaited_readings[$];
    hsfd_pkg::hsfd_pos_t next_pos;
    logic [7:0]          word_crc;
    logic [15:0]         temp_raw;
    logic [15:0]         hum_raw;
    logic                temp_bad;
    int                  fault_count;

    function automatic logic [7:0] crc31_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
            r = r[7] ? ((r << 1) ^ hsfd_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic reading_t scale_reading(input logic [15:0] t_word, input logic [15:0] h_word,
                                               input logic [1:0] status);
        reading_t    r;
        int unsigned t_scaled;
        int unsigned h_scaled;
        t_scaled     = (DEG_SPAN_CENTI * t_word) / FULL_SCALE;
        h_scaled     = (RH_SPAN_CENTI * h_word) / FULL_SCALE;
        r.temp_centi = 15'(int'(t_scaled) - DEG_OFFSET_CENTI);
        r.hum_centi  = 14'(h_scaled);
        r.status     = status;
        return r;
    endfunction

    // Advances the frame state by one received byte; the sixth byte yields a reading.
    function automatic void absorb_byte(input logic [7:0] b, input logic mark);
        logic [1:0] status;
        if (mark || next_pos > hsfd_pkg::POS_H_CRC)
            next_pos = hsfd_pkg::POS_T_HI;
        case (next_pos)
            hsfd_pkg::POS_T_HI:
            begin
                word_crc = crc31_byte(hsfd_pkg::CRC_INIT, b);
                temp_raw = {b, 8'h00};
                next_pos = hsfd_pkg::POS_T_LO;
            end
            hsfd_pkg::POS_T_LO:
            begin
                word_crc      = crc31_byte(word_crc, b);
                temp_raw[7:0] = b;
                next_pos      = hsfd_pkg::POS_T_CRC;
            end
            hsfd_pkg::POS_T_CRC:
            begin
                temp_bad = (word_crc != b);
                word_crc = hsfd_pkg::CRC_INIT;
                next_pos = hsfd_pkg::POS_H_HI;
            end
            hsfd_pkg::POS_H_HI:
            begin
                word_crc = crc31_byte(hsfd_pkg::CRC_INIT, b);
                hum_raw  = {b, 8'h00};
                next_pos = hsfd_pkg::POS_H_LO;
            end
            hsfd_pkg::POS_H_LO:
            begin
                word_crc     = crc31_byte(word_crc, b);
                hum_raw[7:0] = b;
                next_pos     = hsfd_pkg::POS_H_CRC;
            end
            default:
            begin
                status                            = 2'b00;
                status[hsfd_pkg::STATUS_TEMP_BAD] = temp_bad;
                status[hsfd_pkg::STATUS_HUM_BAD]  = (word_crc != b);
                awaited_readings.push_back(scale_reading(temp_raw, hum_raw, status));
                word_crc = hsfd_pkg::CRC_INIT;
                next_pos = hsfd_pkg::POS_T_HI;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t    want;
        logic [31:0] want_tdata;
        if (!rst_n)
        begin
            next_pos    = hsfd_pkg::POS_T_HI;
            word_crc    = hsfd_pkg::CRC_INIT;
            temp_raw    = '0;
            hum_raw     = '0;
            temp_bad    = 1'b0;
            fault_count = 0;
            awaited_readings.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_readings.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected reading, tdata %h tuser %h",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want       = awaited_readings.pop_front();
                    want_tdata = {3'b000, want.hum_centi, want.temp_centi};
                    if (m_axis_tdata !== want_tdata || m_axis_tuser !== want.status)
                    begin
                        fault_count++;
                        $display("%0t: expected temp %0d hum %0d status %0d (tdata %h), got temp %0d hum %0d status %0d (tdata %h)",
                                 $time, $signed(want.temp_centi), want.hum_centi, want.status,
                                 want_tdata, $signed(m_axis_tdata[14:0]), m_axis_tdata[28:15],
                                 m_axis_tuser, m_axis_tdata);
                    end
                end
            end
        end
        mismatches <= fault_count;
        awaited    <= awaited_readings.size();
    end

endmodule

### tb/humidity_sensor_frame_decoder_tb.sv
// Testbench top for the humidity sensor frame decoder: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module humidity_sensor_frame_decoder_tb;

    // Rough number of bytes to offer in the random part of the run.
    localparam int ITEM_TARGET  = 1350;
    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT  = 400000;
    // Length of the long receiver hold-off that fills the frame queue.
    localparam int HOLD_CYCLES  = 300;
    // Cycles allowed after the last reading for anything stray to surface.
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [14:0] temperature_centi, [28:15] humidity_centi, zero fill
    logic [1:0]  m_axis_tuser;   // [1:0] status

    int   mismatches;
    int   awaited;
    int   bytes_sent;
    int   cycles;

    // Both sides stop idling while calm is set. The sender bumps hold_asked to ask the
    // receiver for one long hold-off; the receiver notes it in hold_taken.
    logic calm;
    int   hold_asked;
    int   hold_taken;
    int   hold_left;

    humidity_sensor_frame_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    humidity_sensor_frame_decoder_checker frame_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .awaited       (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offers one byte and returns once the transaction has taken place. Outside the calm
    // stretch the sender idles now and then before offering, so that gaps land on every
    // position within a frame.
    task automatic push_byte(input logic [7:0] value, input logic mark);
        if (!calm)
            while ($urandom_range(0, 99) < 18)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mark;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the first len bytes of a measurement frame. A word whose CRC is to be bad gets
    // its check byte flipped by a non-zero pattern, so that it can never match by chance.
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input bit t_ok, input bit h_ok, input logic mark, input int len);
        logic [7:0] frame [6];
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = hsfd_pkg::crc8_update(hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, t_word[15:8]),
                                      t_word[7:0]);
        h_crc = hsfd_pkg::crc8_update(hsfd_pkg::crc8_update(hsfd_pkg::CRC_INIT, h_word[15:8]),
                                      h_word[7:0]);
        if (!t_ok)
            t_crc ^= 8'($urandom_range(1, 255));
        if (!h_ok)
            h_crc ^= 8'($urandom_range(1, 255));
        frame[0] = t_word[15:8];
        frame[1] = t_word[7:0];
        frame[2] = t_crc;
        frame[3] = h_word[15:8];
        frame[4] = h_word[7:0];
        frame[5] = h_crc;
        for (int i = 0; i < len; i++)
            push_byte(frame[i], (i == 0) ? mark : 1'b0);
    endtask

    // Raw words lean on the ends of the scale, where the scaling is easiest to get wrong.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h0001;
            4:       return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: accepts readings with random stalls, except in the calm stretch, and once
    // holds off for a long stretch so that the frame queue fills and the input stalls.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_taken    = 0;
        hold_left     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_asked != hold_taken)
            begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    // Watchdog: a run that hangs is a failure.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Sender: reset, a directed set of frames, then random frames, then the verdict.
    initial
    begin
        int frames;
        int kind;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        calm          = 1'b0;
        hold_asked    = 0;
        bytes_sent    = 0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Both ends of both scales, with every CRC good and then every CRC bad.
        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1, 6);
        // A frame broken off after two bytes; the start mark that follows drops it, and
        // the new frame carries a bad humidity CRC only.
        send_frame(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1, 2);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1, 6);
        // A frame without a start mark is still counted from the end of the last one.
        send_frame(16'h6666, 16'h9999, 1'b0, 1'b1, 1'b0, 6);

        // Mostly whole frames with random content; some cut short, some plain noise.
        // Frames without a start mark after a cut-short frame run misaligned on purpose.
        frames = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            frames++;
            if (frames == 40)
                hold_asked <= hold_asked + 1;
            if (frames == 100)
                calm <= 1'b1;
            else if (frames == 160)
                calm <= 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 80)
                send_frame(pick_word(), pick_word(), $urandom_range(0, 3) != 0,
                           $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 6);
            else if (kind < 90)
                send_frame(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1, $urandom_range(1, 5));
            else
                repeat ($urandom_range(1, 8))
                    push_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
        s_axis_tvalid <= 1'b0;

        // Let the checker take in the last byte before looking at its count, then wait for
        // every predicted reading and a little longer for anything stray.
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/hsfd_pkg.sv
design/hsfd_front.sv
design/hsfd_fifo.sv
design/hsfd_scale.sv
design/humidity_sensor_frame_decoder.sv
tb/humidity_sensor_frame_decoder_checker.sv
tb/humidity_sensor_frame_decoder_tb.sv
